FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Types, op codes and helpers of the word record statistics block.
// ----------------------------------------------------------------------------
package wrs_pkg;

	localparam int TOP_ENTRIES_DEF = 10;
	localparam int LENGTH_BINS_DEF = 64;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int LETTER_BINS     = 26;
	localparam int LETTER_AW       = 5;
	localparam int MIN_REPEAT      = 2;
	localparam int FILL_MAX        = 15;

	localparam logic [2:0] OP_CLEAR       = 3'd0;
	localparam logic [2:0] OP_ADD         = 3'd1;
	localparam logic [2:0] OP_READ_TOP    = 3'd2;
	localparam logic [2:0] OP_READ_LETTER = 3'd3;
	localparam logic [2:0] OP_READ_LENGTH = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] word_id;
		logic [4:0]  first_letter;
		logic [5:0]  word_len;
		logic [15:0] repeat_count;
		logic [5:0]  read_index;
	} rec_t;

	typedef struct packed {
		logic        entry_valid;
		logic [31:0] bin_count;
		logic [15:0] best_repeat;
		logic [31:0] best_word_id;
		logic [31:0] total_words;
		logic [5:0]  longest_length;
		logic [3:0]  top_fill;
	} res_t;

	// update command for one bin memory
	typedef struct packed {
		logic        clr;
		logic        add;
		logic [15:0] rep;
		logic [31:0] word_id;
	} bin_cmd_t;

	function automatic logic [31:0] cap32(logic [63:0] v);
		logic [31:0] r;
		r = (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/wrs_chan_if.sv
// ----------------------------------------------------------------------------
// wrs_chan_if
// Valid/ready channel carrying one request of type req_t.
// ----------------------------------------------------------------------------
interface wrs_chan_if #(
	parameter type req_t = logic
);
	logic valid;
	logic ready;
	req_t req;

	modport source (output valid, output req, input ready);
	modport sink (input valid, input req, output ready);
endinterface

FILE: rtl/core/word_record_statistics.sv
// Flow: a request is accepted while its bins are read from memory into stage 1,
// and its result is registered from stage 1 once the output register is free.
// Requests do not overlap: the bin memory read of one request is followed by the
// write-back of the same entry, and the input waits while a request is in stage 1.
// Reset: asynchronous, clears all statistics to zero at once through per-bin
// valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// word_record_statistics
// Word counts, letter and length histograms with best word per bin, and a
// sorted top list of repeated words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module word_record_statistics #(
	parameter int TOP_ENTRIES = wrs_pkg::TOP_ENTRIES_DEF,
	parameter int LENGTH_BINS = wrs_pkg::LENGTH_BINS_DEF,
	parameter int COUNT_WIDTH = wrs_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wrs_chan_if.sink   records,
	wrs_chan_if.source results
);

	localparam int LEN_AW = $clog2(LENGTH_BINS);
	localparam int TOP_AW = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
	localparam int TOP_CW = $clog2(TOP_ENTRIES + 1);

	wrs_pkg::rec_t req_s1;
	logic          s1_vld_q;
	logic          rec_fire;
	logic          out_free;
	logic          fire_s1;
	wrs_pkg::res_t res_q;
	logic          res_vld_q;
	wrs_pkg::res_t res_d;

	logic [wrs_pkg::LETTER_AW-1:0] letter_rd_addr;
	logic [LEN_AW-1:0]             length_rd_addr;
	logic [LEN_AW-1:0]             len_bin;
	wrs_pkg::bin_cmd_t             letter_cmd;
	wrs_pkg::bin_cmd_t             length_cmd;
	logic [COUNT_WIDTH-1:0]        letter_count;
	logic [15:0]                   letter_best_rep;
	logic [31:0]                   letter_best_word;
	logic [COUNT_WIDTH-1:0]        length_count;
	logic [15:0]                   length_best_rep;
	logic [31:0]                   length_best_word;

	logic                   is_add;
	logic                   is_clear;
	logic                   letter_ok;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] total_nxt;
	logic [5:0]             max_len_q;
	logic [5:0]             max_len_nxt;

	logic [15:0]            top_rep_q  [TOP_ENTRIES];
	logic [31:0]            top_word_q [TOP_ENTRIES];
	logic [15:0]            top_rep_d  [TOP_ENTRIES];
	logic [31:0]            top_word_d [TOP_ENTRIES];
	logic [TOP_ENTRIES-1:0] gt;
	logic [TOP_ENTRIES-1:0] first;
	logic                   seen;
	logic                   top_ins;
	logic [TOP_CW-1:0]      top_cnt_q;
	logic [TOP_CW-1:0]      top_cnt_nxt;

	// handshake and stage control
	assign records.ready = !s1_vld_q;
	assign rec_fire      = records.valid && records.ready;
	assign out_free      = !res_vld_q || results.ready;
	assign fire_s1       = s1_vld_q && out_free;
	assign results.valid = res_vld_q;
	assign results.req   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (rec_fire) begin
				s1_vld_q <= 1'b1;
			end else if (fire_s1) begin
				s1_vld_q <= 1'b0;
			end
			if (fire_s1) begin
				res_vld_q <= 1'b1;
			end else if (results.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_fire) begin
			req_s1 <= records.req;
		end
		if (fire_s1) begin
			res_q <= res_d;
		end
	end

	// bin memory addresses at acceptance
	assign len_bin = (int'(records.req.word_len) >= LENGTH_BINS) ? LEN_AW'(LENGTH_BINS - 1)
	                                                              : LEN_AW'(records.req.word_len);
	assign letter_rd_addr = (records.req.op == wrs_pkg::OP_READ_LETTER)
	                        ? records.req.read_index[wrs_pkg::LETTER_AW-1:0]
	                        : records.req.first_letter;
	assign length_rd_addr = (records.req.op == wrs_pkg::OP_READ_LENGTH)
	                        ? LEN_AW'(records.req.read_index) : len_bin;

	assign is_add    = (req_s1.op == wrs_pkg::OP_ADD);
	assign is_clear  = (req_s1.op == wrs_pkg::OP_CLEAR);
	assign letter_ok = (req_s1.first_letter < 5'(wrs_pkg::LETTER_BINS));

	assign letter_cmd = '{clr: is_clear, add: is_add && letter_ok,
	                      rep: req_s1.repeat_count, word_id: req_s1.word_id};
	assign length_cmd = '{clr: is_clear, add: is_add,
	                      rep: req_s1.repeat_count, word_id: req_s1.word_id};

	wrs_bin_mem #(
		.DEPTH       (wrs_pkg::LETTER_BINS),
		.AW          (wrs_pkg::LETTER_AW),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_letter_bins (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (rec_fire),
		.rd_addr       (letter_rd_addr),
		.upd_en        (fire_s1),
		.cmd           (letter_cmd),
		.cur_count     (letter_count),
		.cur_best_rep  (letter_best_rep),
		.cur_best_word (letter_best_word)
	);

	wrs_bin_mem #(
		.DEPTH       (LENGTH_BINS),
		.AW          (LEN_AW),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_length_bins (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (rec_fire),
		.rd_addr       (length_rd_addr),
		.upd_en        (fire_s1),
		.cmd           (length_cmd),
		.cur_count     (length_count),
		.cur_best_rep  (length_best_rep),
		.cur_best_word (length_best_word)
	);

	// global counters
	always_comb begin
		total_nxt   = total_q;
		max_len_nxt = max_len_q;
		if (is_clear) begin
			total_nxt = '0;
		end else if (is_add) begin
			total_nxt = (total_q == '1) ? total_q : total_q + 1'b1;
			if (req_s1.word_len > max_len_q) begin
				max_len_nxt = req_s1.word_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			max_len_q <= '0;
			top_cnt_q <= '0;
		end else if (fire_s1) begin
			total_q   <= total_nxt;
			max_len_q <= max_len_nxt;
			top_cnt_q <= top_cnt_nxt;
		end
	end

	// top list: compare every entry, shift the tail down one place
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < TOP_ENTRIES; i++) begin
			gt[i]    = (TOP_CW'(i) >= top_cnt_q) || (req_s1.repeat_count > top_rep_q[i]);
			first[i] = gt[i] && !seen;
			seen     = seen || gt[i];
		end
		top_ins = is_add && (req_s1.repeat_count >= 16'(wrs_pkg::MIN_REPEAT))
		          && gt[TOP_ENTRIES-1];
		top_rep_d[0]  = top_rep_q[0];
		top_word_d[0] = top_word_q[0];
		for (int i = 1; i < TOP_ENTRIES; i++) begin
			top_rep_d[i]  = gt[i] ? top_rep_q[i-1]  : top_rep_q[i];
			top_word_d[i] = gt[i] ? top_word_q[i-1] : top_word_q[i];
		end
		for (int i = 0; i < TOP_ENTRIES; i++) begin
			if (first[i]) begin
				top_rep_d[i]  = req_s1.repeat_count;
				top_word_d[i] = req_s1.word_id;
			end
		end
		if (is_clear) begin
			top_cnt_nxt = '0;
		end else if (top_ins && (int'(top_cnt_q) < TOP_ENTRIES)) begin
			top_cnt_nxt = top_cnt_q + 1'b1;
		end else begin
			top_cnt_nxt = top_cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && top_ins) begin
			for (int i = 0; i < TOP_ENTRIES; i++) begin
				top_rep_q[i]  <= top_rep_d[i];
				top_word_q[i] <= top_word_d[i];
			end
		end
	end

	// result
	always_comb begin
		res_d                = '0;
		res_d.total_words    = wrs_pkg::cap32(64'(total_nxt));
		res_d.longest_length = max_len_nxt;
		res_d.top_fill       = (int'(top_cnt_nxt) > wrs_pkg::FILL_MAX)
		                       ? 4'(wrs_pkg::FILL_MAX) : 4'(top_cnt_nxt);
		unique case (req_s1.op)
			wrs_pkg::OP_READ_TOP: begin
				if ((int'(req_s1.read_index) < int'(top_cnt_q))
				    && (int'(req_s1.read_index) < TOP_ENTRIES)) begin
					res_d.entry_valid  = 1'b1;
					res_d.best_repeat  = top_rep_q[TOP_AW'(req_s1.read_index)];
					res_d.best_word_id = top_word_q[TOP_AW'(req_s1.read_index)];
				end
			end
			wrs_pkg::OP_READ_LETTER: begin
				if (int'(req_s1.read_index) < wrs_pkg::LETTER_BINS) begin
					res_d.entry_valid  = (letter_best_rep != '0);
					res_d.bin_count    = wrs_pkg::cap32(64'(letter_count));
					res_d.best_repeat  = letter_best_rep;
					res_d.best_word_id = letter_best_word;
				end
			end
			wrs_pkg::OP_READ_LENGTH: begin
				if (int'(req_s1.read_index) < LENGTH_BINS) begin
					res_d.entry_valid  = (length_best_rep != '0);
					res_d.bin_count    = wrs_pkg::cap32(64'(length_count));
					res_d.best_repeat  = length_best_rep;
					res_d.best_word_id = length_best_word;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMPL(a_fill_bound, 1'b1, int'(top_cnt_q) <= TOP_ENTRIES)
	`ASSERT_NEXT(a_clear_empties, fire_s1 && is_clear, top_cnt_q == '0 && total_q == '0)
	`ASSERT_NEXT(a_max_len_mono, 1'b1, max_len_q >= $past(max_len_q))
	`ASSERT_NEXT(a_done_to_out, fire_s1, res_vld_q)

endmodule

FILE: rtl/core/wrs_bin_mem.sv
// ----------------------------------------------------------------------------
// wrs_bin_mem
// Histogram bin store: count and best word per bin in one synchronous
// memory, per-entry valid bits, read then read-modify-write update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrs_bin_mem #(
	parameter int DEPTH       = wrs_pkg::LENGTH_BINS_DEF,
	parameter int AW          = $clog2(DEPTH),
	parameter int COUNT_WIDTH = wrs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	input  logic                   upd_en,
	input  wrs_pkg::bin_cmd_t      cmd,
	output logic [COUNT_WIDTH-1:0] cur_count,
	output logic [15:0]            cur_best_rep,
	output logic [31:0]            cur_best_word
);

	localparam int EW = COUNT_WIDTH + 48;

	logic [EW-1:0]          mem [DEPTH];
	logic [DEPTH-1:0]       vld_q;
	logic [EW-1:0]          rd_data_s1;
	logic                   rd_vld_s1;
	logic [AW-1:0]          addr_s1;
	logic [COUNT_WIDTH-1:0] new_count;
	logic                   take_best;
	logic [EW-1:0]          new_entry;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en && cmd.add && !cmd.clr) begin
			mem[addr_s1] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
			if (upd_en) begin
				if (cmd.clr) begin
					vld_q <= '0;
				end else if (cmd.add) begin
					vld_q[addr_s1] <= 1'b1;
				end
			end
		end
	end

	// unwritten entries read as zero
	always_comb begin
		if (rd_vld_s1) begin
			{cur_count, cur_best_rep, cur_best_word} = rd_data_s1;
		end else begin
			{cur_count, cur_best_rep, cur_best_word} = '0;
		end
	end

	assign new_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
	assign take_best = (cmd.rep >= 16'(wrs_pkg::MIN_REPEAT)) && (cmd.rep > cur_best_rep);
	assign new_entry = take_best ? {new_count, cmd.rep, cmd.word_id}
	                             : {new_count, cur_best_rep, cur_best_word};

	`ASSERT_NEXT(a_bin_clr, upd_en && cmd.clr, vld_q == '0)

endmodule
